[rtl/core/axis_jog_latch_motor_drive_assert.svh]
// Assertion macros of the axis jog drive, used by the ajl_step module.
`ifndef AXIS_JOG_LATCH_MOTOR_DRIVE_ASSERT_SVH
`define AXIS_JOG_LATCH_MOTOR_DRIVE_ASSERT_SVH
`ifndef SYNTH
`define AJL_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ajl assertion failed");
`define AJL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ajl assertion failed");
`else
`define AJL_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define AJL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/ajl_pkg.sv]
// Types and constants of the axis jog drive.
`timescale 1ns / 1ps
package ajl_pkg;

    typedef logic [2:0] t_mode;
    typedef logic       t_cfg_idx;

    localparam t_mode MODE_IDLE    = 3'd0;
    localparam t_mode MODE_JOG_FWD = 3'd1;
    localparam t_mode MODE_JOG_REV = 3'd2;
    localparam t_mode MODE_RUN_FWD = 3'd3;
    localparam t_mode MODE_RUN_REV = 3'd4;

    localparam t_cfg_idx CFG_LATCH_TICKS = 1'b0;
    localparam t_cfg_idx CFG_MAX_DUTY    = 1'b1;

    localparam logic [7:0] LATCH_TICKS_RST = 8'd100;
    localparam logic [7:0] MAX_DUTY_RST    = 8'd255;
    localparam logic [7:0] HOLD_MAX        = 8'd255;

    typedef struct packed {
        logic [7:0] latch_ticks;
        logic [7:0] max_duty;
    } t_cfg;

    typedef struct packed {
        logic fwd_button;
        logic rev_button;
        logic fwd_limit;
        logic rev_limit;
    } t_in;

    typedef struct packed {
        logic       drive_enable;
        logic       turn_fwd;
        logic       turn_rev;
        logic [7:0] pwm_duty;
        logic       fwd_end_lamp;
        logic       rev_end_lamp;
        t_mode      motion_state;
    } t_res;

endpackage

[rtl/core/ajl_in_if.sv]
// Input channel of the axis jog drive: one ramp tick per transfer.
`timescale 1ns / 1ps
interface ajl_in_if;
    logic valid;
    logic ready;
    logic fwd_button;
    logic rev_button;
    logic fwd_limit;
    logic rev_limit;

    modport source (output valid, fwd_button, rev_button, fwd_limit, rev_limit, input ready);
    modport sink (input valid, fwd_button, rev_button, fwd_limit, rev_limit, output ready);
endinterface

[rtl/core/ajl_out_if.sv]
// Result channel of the axis jog drive: drive lines and lamps per transfer.
`timescale 1ns / 1ps
interface ajl_out_if;
    logic       valid;
    logic       ready;
    logic       drive_enable;
    logic       turn_fwd;
    logic       turn_rev;
    logic [7:0] pwm_duty;
    logic       fwd_end_lamp;
    logic       rev_end_lamp;
    logic [2:0] motion_state;

    modport source (output valid, drive_enable, turn_fwd, turn_rev, pwm_duty,
                    fwd_end_lamp, rev_end_lamp, motion_state, input ready);
    modport sink (input valid, drive_enable, turn_fwd, turn_rev, pwm_duty,
                  fwd_end_lamp, rev_end_lamp, motion_state, output ready);
endinterface

[rtl/core/ajl_cfg_if.sv]
// Configuration write channel of the axis jog drive.
`timescale 1ns / 1ps
interface ajl_cfg_if
    import ajl_pkg::*;
;
    logic       valid;
    logic       ready;
    t_cfg_idx   index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/axis_jog_latch_motor_drive.sv]
// Top level of the axis jog drive: input register, tick update and result register.
//
//  Channel  Dir  Payload
//  i_in     in   fwd_button, rev_button, fwd_limit, rev_limit
//  o_out    out  drive_enable, turn_fwd, turn_rev, pwm_duty, end lamps, motion_state
//  i_cfg    in   index, data (latch_ticks, max_duty)
//
// A tick transfer is registered in the input register, updated by the motion logic and
// loaded into the result register once the result side can take it, and its result
// transfer is then offered from the result register.
// One tick is taken in every cycle while the result side keeps up.
// A stall on the result side holds both registers and backs up into i_in.
// Reset clears the motion state to idle and loads the register defaults.
`timescale 1ns / 1ps
module axis_jog_latch_motor_drive
    import ajl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    ajl_in_if.sink     i_in,
    ajl_out_if.source  o_out,
    ajl_cfg_if.sink    i_cfg
);

    logic r_in_valid;
    t_in  r_in;
    logic r_out_valid;
    t_res r_out;
    logic w_adv;
    t_res w_res;
    t_cfg w_cfg;

    assign w_adv      = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.fwd_button <= i_in.fwd_button;
            r_in.rev_button <= i_in.rev_button;
            r_in.fwd_limit  <= i_in.fwd_limit;
            r_in.rev_limit  <= i_in.rev_limit;
        end
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    ajl_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    ajl_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_in    (r_in),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    assign o_out.valid        = r_out_valid;
    assign o_out.drive_enable = r_out.drive_enable;
    assign o_out.turn_fwd     = r_out.turn_fwd;
    assign o_out.turn_rev     = r_out.turn_rev;
    assign o_out.pwm_duty     = r_out.pwm_duty;
    assign o_out.fwd_end_lamp = r_out.fwd_end_lamp;
    assign o_out.rev_end_lamp = r_out.rev_end_lamp;
    assign o_out.motion_state = r_out.motion_state;

endmodule

[rtl/core/ajl_cfg.sv]
// Configuration registers of the axis jog drive.
`timescale 1ns / 1ps
module ajl_cfg
    import ajl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    ajl_cfg_if.sink   i_cfg,
    output t_cfg      o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.latch_ticks <= LATCH_TICKS_RST;
            r_cfg.max_duty    <= MAX_DUTY_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_LATCH_TICKS: r_cfg.latch_ticks <= i_cfg.data;
                CFG_MAX_DUTY:    r_cfg.max_duty    <= i_cfg.data;
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

endmodule

[rtl/core/ajl_step.sv]
// Motion state of the axis and its per-tick update.
`timescale 1ns / 1ps
`include "axis_jog_latch_motor_drive_assert.svh"
module ajl_step
    import ajl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_adv,
    input  t_in  i_in,
    input  t_cfg i_cfg,
    output t_res o_res
);

    t_mode      r_mode;
    logic [7:0] r_duty;
    logic [7:0] r_hold;
    t_mode      n_mode;
    logic [7:0] n_duty;
    logic [7:0] n_hold;

    always_comb begin
        logic btn;
        logic lim;
        t_mode run_mode;
        n_mode = r_mode;
        n_duty = r_duty;
        n_hold = r_hold;
        btn = 1'b0;
        lim = 1'b0;
        run_mode = MODE_RUN_FWD;
        if (r_mode > MODE_RUN_REV) begin
            n_mode = MODE_IDLE;
            n_duty = 8'd0;
            n_hold = 8'd0;
        end
        if (n_mode == MODE_IDLE) begin
            if (i_in.fwd_button && !i_in.fwd_limit) begin
                n_mode = MODE_JOG_FWD;
                n_hold = 8'd0;
            end else if (i_in.rev_button && !i_in.rev_limit) begin
                n_mode = MODE_JOG_REV;
                n_hold = 8'd0;
            end
        end
        unique case (n_mode) inside
            MODE_JOG_FWD, MODE_JOG_REV: begin
                btn      = (n_mode == MODE_JOG_FWD) ? i_in.fwd_button : i_in.rev_button;
                lim      = (n_mode == MODE_JOG_FWD) ? i_in.fwd_limit : i_in.rev_limit;
                run_mode = (n_mode == MODE_JOG_FWD) ? MODE_RUN_FWD : MODE_RUN_REV;
                if (!btn || lim) begin
                    n_mode = MODE_IDLE;
                    n_duty = 8'd0;
                    n_hold = 8'd0;
                end else begin
                    if (n_duty < i_cfg.max_duty) begin
                        n_duty = n_duty + 8'd1;
                        if (n_hold < HOLD_MAX) begin
                            n_hold = n_hold + 8'd1;
                        end
                    end
                    if (n_hold > i_cfg.latch_ticks) begin
                        n_mode = run_mode;
                    end
                end
            end
            MODE_RUN_FWD, MODE_RUN_REV: begin
                lim = (n_mode == MODE_RUN_FWD) ? i_in.fwd_limit : i_in.rev_limit;
                if (lim) begin
                    n_mode = MODE_IDLE;
                    n_duty = 8'd0;
                    n_hold = 8'd0;
                end else if (n_duty < i_cfg.max_duty) begin
                    n_duty = n_duty + 8'd1;
                end
            end
            default: begin
                n_mode = MODE_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_duty <= 8'd0;
            r_hold <= 8'd0;
        end else if (i_adv) begin
            r_mode <= n_mode;
            r_duty <= n_duty;
            r_hold <= n_hold;
        end
    end

    assign o_res.drive_enable = (n_mode != MODE_IDLE);
    assign o_res.turn_fwd     = (n_mode == MODE_JOG_FWD) || (n_mode == MODE_RUN_FWD);
    assign o_res.turn_rev     = (n_mode == MODE_JOG_REV) || (n_mode == MODE_RUN_REV);
    assign o_res.pwm_duty     = n_duty;
    assign o_res.fwd_end_lamp = i_in.fwd_limit;
    assign o_res.rev_end_lamp = i_in.rev_limit;
    assign o_res.motion_state = n_mode;

    `AJL_ASSERT_NOW(a_idle_clear, i_clk, i_rst_n, r_mode == MODE_IDLE,
        (r_duty == 8'd0) && (r_hold == 8'd0))
    `AJL_ASSERT_NOW(a_run_latched, i_clk, i_rst_n,
        (r_mode == MODE_RUN_FWD) || (r_mode == MODE_RUN_REV), (r_hold != 8'd0) && (r_duty != 8'd0))
    `AJL_ASSERT_NEXT(a_hold_state, i_clk, i_rst_n, !i_adv,
        $stable(r_mode) && $stable(r_duty) && $stable(r_hold))
    `AJL_ASSERT_NEXT(a_duty_step, i_clk, i_rst_n, i_adv,
        (r_duty == 8'd0) || (r_duty == $past(r_duty)) || (r_duty == ($past(r_duty) + 8'd1)))

endmodule

[bench/tb.sv]
// Self-checking testbench of the axis jog drive with a tick predictor and random handshakes.
`timescale 1ns / 1ps
module tb;
    import ajl_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASES = 8;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ajl_in_if  tick_if();
    ajl_out_if drive_if();
    ajl_cfg_if cfg_if();

    axis_jog_latch_motor_drive dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (tick_if),
        .o_out   (drive_if),
        .i_cfg   (cfg_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_in  pending_ticks[$];
    t_res expected_outputs[$];

    t_mode      drv_mode = MODE_IDLE;
    logic [7:0] drv_duty = '0;
    logic [7:0] drv_hold = '0;
    logic [7:0] cfg_latch = LATCH_TICKS_RST;
    logic [7:0] cfg_max_duty = MAX_DUTY_RST;

    int  send_idle_pct = 24;
    int  recv_idle_pct = 66;
    int  mismatches = 0;
    int  cycles = 0;
    bit  tick_taken = 1'b0;

    int phase_latch[PHASES] = '{100, 1, 254, 10, 1, 254, 0, 20};
    int phase_max[PHASES]   = '{255, 1, 255, 4, 255, 1, 0, 20};

    initial begin
        tick_if.valid = 1'b0;
        tick_if.fwd_button = 1'b0;
        tick_if.rev_button = 1'b0;
        tick_if.fwd_limit = 1'b0;
        tick_if.rev_limit = 1'b0;
        drive_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = CFG_LATCH_TICKS;
        cfg_if.data = '0;
    end

    function automatic void stop_motor();
        drv_mode = MODE_IDLE;
        drv_duty = '0;
        drv_hold = '0;
    endfunction

    function automatic void jog_step(logic btn, logic lim, t_mode run_mode);
        if (!btn || lim) begin
            stop_motor();
        end else begin
            if (drv_duty < cfg_max_duty) begin
                drv_duty = drv_duty + 8'd1;
                if (drv_hold < HOLD_MAX)
                    drv_hold = drv_hold + 8'd1;
            end
            if (drv_hold > cfg_latch)
                drv_mode = run_mode;
        end
    endfunction

    function automatic t_res motion_tick(t_in t);
        t_res r;
        if (drv_mode > MODE_RUN_REV)
            stop_motor();
        if (drv_mode == MODE_IDLE) begin
            if (t.fwd_button && !t.fwd_limit) begin
                drv_mode = MODE_JOG_FWD;
                drv_hold = '0;
            end else if (t.rev_button && !t.rev_limit) begin
                drv_mode = MODE_JOG_REV;
                drv_hold = '0;
            end
        end
        case (drv_mode)
            MODE_JOG_FWD: jog_step(t.fwd_button, t.fwd_limit, MODE_RUN_FWD);
            MODE_JOG_REV: jog_step(t.rev_button, t.rev_limit, MODE_RUN_REV);
            MODE_RUN_FWD: begin
                if (t.fwd_limit)
                    stop_motor();
                else if (drv_duty < cfg_max_duty)
                    drv_duty = drv_duty + 8'd1;
            end
            MODE_RUN_REV: begin
                if (t.rev_limit)
                    stop_motor();
                else if (drv_duty < cfg_max_duty)
                    drv_duty = drv_duty + 8'd1;
            end
            default: ;
        endcase
        r.drive_enable = (drv_mode != MODE_IDLE);
        r.turn_fwd = (drv_mode == MODE_JOG_FWD) || (drv_mode == MODE_RUN_FWD);
        r.turn_rev = (drv_mode == MODE_JOG_REV) || (drv_mode == MODE_RUN_REV);
        r.pwm_duty = drv_duty;
        r.fwd_end_lamp = t.fwd_limit;
        r.rev_end_lamp = t.rev_limit;
        r.motion_state = drv_mode;
        return r;
    endfunction

    task automatic report(string msg);
        $display("ERROR at cycle %0d: %s", cycles, msg);
        mismatches++;
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want)
            report($sformatf("%s is %0d, predicted %0d", name, got, want));
    endtask

    // Other-direction fields are random; a reverse tick never lets forward win the start.
    function automatic void push_tick(bit fwd_dir, bit btn, bit lim);
        t_in t;
        t = t_in'($urandom_range(15));
        if (fwd_dir) begin
            t.fwd_button = btn;
            t.fwd_limit = lim;
        end else begin
            t.rev_button = btn;
            t.rev_limit = lim;
            if (t.fwd_button && !t.fwd_limit)
                t.fwd_button = 1'b0;
        end
        pending_ticks.push_back(t);
    endfunction

    function automatic void jog_sequence(bit fwd_dir, bit latched);
        int hold;
        int run;
        if (latched)
            hold = cfg_latch + 1 + $urandom_range(4);
        else
            hold = $urandom_range(1, (cfg_latch < 30) ? cfg_latch : 30);
        for (int i = 0; i < hold; i++)
            push_tick(fwd_dir, 1'b1, 1'b0);
        if (latched) begin
            run = $urandom_range(20);
            for (int i = 0; i < run; i++)
                push_tick(fwd_dir, 1'($urandom_range(1)), 1'b0);
            push_tick(fwd_dir, 1'($urandom_range(1)), 1'b1);
        end else if ($urandom_range(1)) begin
            push_tick(fwd_dir, 1'b0, 1'($urandom_range(1)));
        end else begin
            push_tick(fwd_dir, 1'($urandom_range(1)), 1'b1);
        end
    endfunction

    // The phase ends holding a button so that the next register writes land during motion.
    function automatic void gen_phase(int n);
        int made;
        int pick;
        int hold;
        made = pending_ticks.size();
        while (pending_ticks.size() - made < n) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                jog_sequence(1'($urandom_range(1)), 1'b0);
            end else if (pick < 70) begin
                jog_sequence(1'($urandom_range(1)), 1'b1);
            end else begin
                for (int i = $urandom_range(1, 8); i > 0; i--)
                    pending_ticks.push_back(t_in'($urandom_range(15)));
            end
        end
        hold = cfg_latch + 1 + $urandom_range(10);
        pick = $urandom_range(1);
        for (int i = 0; i < hold; i++)
            push_tick(1'(pick), 1'b1, 1'b0);
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [7:0] value);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= value;
        do
            @(posedge i_clk);
        while (!(cfg_if.valid && cfg_if.ready));
        case (idx)
            CFG_LATCH_TICKS: cfg_latch = value;
            CFG_MAX_DUTY: cfg_max_duty = value;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_ticks.size() != 0 || expected_outputs.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_pacing(int sel);
        case (sel)
            0: begin
                send_idle_pct = 24;
                recv_idle_pct = 66;
            end
            1: begin
                send_idle_pct = 66;
                recv_idle_pct = 24;
            end
            default: begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    initial begin
        t_in directed[] = '{4'b0000, 4'b1111, 4'b1110, 4'b0100, 4'b0100, 4'b0100, 4'b0000,
                            4'b0001, 4'b1100, 4'b0100, 4'b1000, 4'b1010, 4'b0111, 4'b1000,
                            4'b1000, 4'b1000, 4'b1001, 4'b1010, 4'b0101};
        int lt;
        int md;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        set_pacing(0);
        write_reg(CFG_LATCH_TICKS, 8'd2);
        write_reg(CFG_MAX_DUTY, 8'd3);
        foreach (directed[i])
            pending_ticks.push_back(directed[i]);

        for (int p = 0; p < PHASES; p++) begin
            drain();
            set_pacing((p * 3) / PHASES);
            lt = (phase_latch[p] == 0) ? $urandom_range(1, 254) : phase_latch[p];
            md = (phase_max[p] == 0) ? $urandom_range(1, 255) : phase_max[p];
            write_reg(CFG_LATCH_TICKS, 8'(lt));
            write_reg(CFG_MAX_DUTY, 8'(md));
            gen_phase(10);
        end

        drain();
        if (expected_outputs.size() != 0)
            report("predicted results left over at the end");
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        t_in t;
        if (i_rst_n && tick_if.valid && tick_if.ready) begin
            t.fwd_button = tick_if.fwd_button;
            t.rev_button = tick_if.rev_button;
            t.fwd_limit = tick_if.fwd_limit;
            t.rev_limit = tick_if.rev_limit;
            expected_outputs.push_back(motion_tick(t));
            pending_ticks.pop_front();
            tick_taken = 1'b1;
        end
    end

    always @(negedge i_clk) begin
        t_in nxt;
        if (!i_rst_n) begin
            tick_if.valid <= 1'b0;
            drive_if.ready <= 1'b0;
        end else begin
            if (!tick_if.valid || tick_taken) begin
                tick_taken = 1'b0;
                if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pending_ticks[0];
                    tick_if.valid <= 1'b1;
                    tick_if.fwd_button <= nxt.fwd_button;
                    tick_if.rev_button <= nxt.rev_button;
                    tick_if.fwd_limit <= nxt.fwd_limit;
                    tick_if.rev_limit <= nxt.rev_limit;
                end else begin
                    tick_if.valid <= 1'b0;
                end
            end
            drive_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && drive_if.valid && drive_if.ready) begin
            if (expected_outputs.size() == 0) begin
                report("result transfer with no tick outstanding");
            end else begin
                want = expected_outputs.pop_front();
                check_field("drive_enable", drive_if.drive_enable, want.drive_enable);
                check_field("turn_fwd", drive_if.turn_fwd, want.turn_fwd);
                check_field("turn_rev", drive_if.turn_rev, want.turn_rev);
                check_field("pwm_duty", drive_if.pwm_duty, want.pwm_duty);
                check_field("fwd_end_lamp", drive_if.fwd_end_lamp, want.fwd_end_lamp);
                check_field("rev_end_lamp", drive_if.rev_end_lamp, want.rev_end_lamp);
                check_field("motion_state", drive_if.motion_state, want.motion_state);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule
